### rtl/rlim_pkg.sv
// ----------------------------------------------------------------------------
// rlim_pkg
// Shared types and constants for the per-source connection rate limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package rlim_pkg;

  localparam int ADDR_W    = 32;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 8;
  localparam int MAXPS_W   = 8;
  localparam int COOL_W    = 16;
  localparam int VERDICT_W = 2;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_SECOND = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_COOLDOWN = 8'd1;

  localparam logic [MAXPS_W-1:0] MAX_PER_SECOND_RST = 8'd2;
  localparam logic [COOL_W-1:0]  ALERT_COOLDOWN_RST = 16'd30;

  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_ALLOW = 2'd0,
    VERDICT_BLOCK = 2'd1,
    VERDICT_ALERT = 2'd2
  } verdict_t;

  // one tracked source, as stored in a table word
  typedef struct packed {
    logic [ADDR_W-1:0]  tracked_address;
    logic [TIME_W-1:0]  seen_second;
    logic [TIME_W-1:0]  alerted_second;
    logic [COUNT_W-1:0] attempt_count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // configuration register values
  typedef struct packed {
    logic [MAXPS_W-1:0] max_per_second;
    logic [COOL_W-1:0]  alert_cooldown;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/per_source_connection_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_source_connection_rate_limiter
// Tracks connection attempts per source address in a table memory and
// returns allow, block or block-with-alert for each attempt.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                   | Transfer
//  ---------+-----------------------------------------+------------------------
//  input    | in_source_address, in_now_seconds       | in_valid & in_ready
//  result   | out_verdict                             | out_valid & out_ready
//  config   | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//
//  An item whose source matches entry k ends the table scan at that entry;
//  a miss scans every entry. The scan runs through the table's single read
//  port, and no new input is taken until the item's result is registered.
//  After reset the table is cleared one entry a cycle, every entry in turn,
//  with in_ready low; configuration writes are taken throughout.
//  A stalled result is held in the output register; the block then waits
//  with the next result until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module per_source_connection_rate_limiter #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rlim_pkg::ADDR_W-1:0]    in_source_address,
  input  wire logic [rlim_pkg::TIME_W-1:0]    in_now_seconds,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rlim_pkg::VERDICT_W-1:0]      out_verdict,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rlim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rlim_pkg::CFG_DAT_W-1:0] cfg_data
);
  import rlim_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  cfg_t               cfg_r;
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  assign cfg_ready = 1'b1;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_per_second <= MAX_PER_SECOND_RST;
      cfg_r.alert_cooldown <= ALERT_COOLDOWN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_PER_SECOND: cfg_r.max_per_second <= cfg_data[MAXPS_W-1:0];
        CFG_ALERT_COOLDOWN: cfg_r.alert_cooldown <= cfg_data[COOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rlim_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_source_address(in_source_address),
    .in_now_seconds   (in_now_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_verdict      (out_verdict),
    .ram_wr_en        (ram_wr_en),
    .ram_wr_addr      (ram_wr_addr),
    .ram_wr_data      (ram_wr_data),
    .ram_rd_en        (ram_rd_en),
    .ram_rd_addr      (ram_rd_addr),
    .ram_rd_data      (ram_rd_data)
  );

  rlim_ram #(
    .DEPTH(TABLE_ENTRIES),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

endmodule

`default_nettype wire

### rtl/rlim_ram.sv
// ----------------------------------------------------------------------------
// rlim_ram
// Single-port-write, single-port-read table memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rlim_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/rlim_ctrl.sv
// ----------------------------------------------------------------------------
// rlim_ctrl
// Table sequencer: clears the table after reset, scans it for a source,
// updates the matching or replaced entry and registers the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module rlim_ctrl #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire rlim_pkg::cfg_t                      cfg,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [rlim_pkg::ADDR_W-1:0]         in_source_address,
  input  wire logic [rlim_pkg::TIME_W-1:0]         in_now_seconds,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [rlim_pkg::VERDICT_W-1:0]           out_verdict,
  output logic                                     ram_wr_en,
  output logic [$clog2(TABLE_ENTRIES)-1:0]         ram_wr_addr,
  output logic [rlim_pkg::ENTRY_W-1:0]             ram_wr_data,
  output logic                                     ram_rd_en,
  output logic [$clog2(TABLE_ENTRIES)-1:0]         ram_rd_addr,
  input  wire logic [rlim_pkg::ENTRY_W-1:0]        ram_rd_data
);
  import rlim_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  state_t             state_r;
  logic [IDX_W-1:0]   idx_r;        // clear index, then scan issue index
  logic               issue_done_r; // last scan read issued
  logic               pend_r;       // read data valid this cycle
  logic [IDX_W-1:0]   pend_idx_r;
  logic [IDX_W-1:0]   rp_r;         // round-robin replace pointer
  logic [IDX_W-1:0]   ent_idx_r;
  logic               hit_r;
  entry_t             ent_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [TIME_W-1:0]  now_r;
  verdict_t           verdict_r;
  logic               out_valid_r;
  verdict_t           out_verdict_r;

  entry_t             rd_ent;
  entry_t             new_ent;
  verdict_t           verdict_nxt;
  logic [COUNT_W-1:0] cnt_inc;
  logic [TIME_W-1:0]  elapsed;

  assign rd_ent = entry_t'(ram_rd_data);

  // work out the updated entry and the verdict
  always_comb begin
    new_ent     = ent_r;
    verdict_nxt = VERDICT_ALLOW;
    cnt_inc     = (ent_r.attempt_count != COUNT_SAT) ?
                  ent_r.attempt_count + COUNT_W'(1) : ent_r.attempt_count;
    elapsed     = now_r - ent_r.alerted_second;
    if (!hit_r) begin
      new_ent.tracked_address = addr_r;
      new_ent.seen_second     = now_r;
      new_ent.alerted_second  = '0;
      new_ent.attempt_count   = COUNT_W'(1);
    end else if (ent_r.seen_second == now_r) begin
      new_ent.attempt_count = cnt_inc;
      if (cnt_inc > cfg.max_per_second) begin
        if (elapsed >= TIME_W'(cfg.alert_cooldown)) begin
          new_ent.alerted_second = now_r;
          verdict_nxt            = VERDICT_ALERT;
        end else begin
          verdict_nxt = VERDICT_BLOCK;
        end
      end
    end else begin
      new_ent.seen_second   = now_r;
      new_ent.attempt_count = COUNT_W'(1);
    end
  end

  // memory port drive
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = ent_idx_r;
    ram_wr_data = new_ent;
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_r;
    case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_r;
        ram_wr_data = '0;
      end
      ST_SCAN: begin
        ram_rd_en = !issue_done_r;
      end
      ST_UPDATE: begin
        ram_wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      idx_r        <= '0;
      issue_done_r <= 1'b0;
      pend_r       <= 1'b0;
      rp_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // drop the result once taken; the emit state reloads it itself
      if (out_valid_r && out_ready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          if (idx_r == LAST_IDX) begin
            idx_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            addr_r       <= in_source_address;
            now_r        <= in_now_seconds;
            idx_r        <= '0;
            issue_done_r <= 1'b0;
            pend_r       <= 1'b0;
            state_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend_r     <= !issue_done_r;
          pend_idx_r <= idx_r;
          if (!issue_done_r) begin
            idx_r <= idx_r + IDX_W'(1);
            if (idx_r == LAST_IDX) begin
              issue_done_r <= 1'b1;
            end
          end
          // compare returned entry; lowest index wins
          if (pend_r) begin
            if (rd_ent.tracked_address == addr_r) begin
              hit_r     <= 1'b1;
              ent_idx_r <= pend_idx_r;
              ent_r     <= rd_ent;
              state_r   <= ST_UPDATE;
            end else if (pend_idx_r == LAST_IDX) begin
              hit_r     <= 1'b0;
              ent_idx_r <= rp_r;
              ent_r     <= rd_ent;
              state_r   <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          verdict_r <= verdict_nxt;
          if (!hit_r) begin
            rp_r <= (rp_r == LAST_IDX) ? '0 : rp_r + IDX_W'(1);
          end
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          // hold until the output slot is free
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_verdict_r <= verdict_r;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/rlim_checker.sv
// ----------------------------------------------------------------------------
// rlim_checker
// Port-level checks for the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rlim_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [rlim_pkg::VERDICT_W-1:0] out_verdict
);
  import rlim_pkg::*;

  // table clear runs after reset: no input transfer right after it
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  // one item at a time: input closes after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // verdict code is one of the three defined values
  a_verdict_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == VERDICT_ALLOW || out_verdict == VERDICT_BLOCK ||
                   out_verdict == VERDICT_ALERT))
    else $error("undefined verdict code");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_verdict)))
    else $error("stalled result changed");

endmodule

bind per_source_connection_rate_limiter rlim_checker u_rlim_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_verdict(out_verdict)
);

`default_nettype wire
